>>> rtl/rpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB palette builder package
// Shared constants and types for the palette builder and its search cells.
// ----------------------------------------------------------------------------
package rpb_pkg;

  // Default number of palette entries.
  localparam int DEFAULT_PALETTE_DEPTH = 256;

  // Each colour channel keeps its top three bits (mask 0xe0).
  localparam int CHANNEL_BITS = 3;
  localparam int KEY_W        = 3 * CHANNEL_BITS;
  localparam int ALPHA_W      = 8;

  // Reduced RGB key as compared by the cells.
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [ALPHA_W-1:0] alpha_t;

  // Control flags that travel with an item along the chain.
  typedef struct packed {
    logic valid;     // the stage holds an item
    logic clear;     // the item empties the palette as it passes
    logic resolved;  // a cell has already matched or claimed the item
    logic mapped;    // the item has a palette index
    logic added;     // the item created a new entry
  } ctrl_t;

endpackage : rpb_pkg
`default_nettype wire

>>> rtl/rgb_palette_builder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An item passes through the register of every cell of the search chain in
// turn; its result is presented from the register of the last cell.
// Throughput: one item per cycle unless stalled; items follow down the chain.
// The whole chain stalls while the last stage holds a result not yet taken.
// Reset clears every occupancy bit and stage valid at once; no clearing pass.
// ----------------------------------------------------------------------------
// RGB palette builder
// First-fit palette of reduced RGB colours built as a chain of search cells.
// ----------------------------------------------------------------------------
module rgb_palette_builder_unit
  import rpb_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pixel_valid,
  output logic            pixel_ready,
  input  wire logic       first_of_image,
  input  wire logic [7:0] alpha_in,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      palette_index,
  output logic            mapped,
  output logic            added_entry,
  output logic [8:0]      entries_used
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);

  ctrl_t         stage_ctrl  [0:PALETTE_DEPTH];
  key_t          stage_key   [0:PALETTE_DEPTH];
  alpha_t        stage_alpha [0:PALETTE_DEPTH];
  logic [IW-1:0] stage_index [0:PALETTE_DEPTH];
  logic [CW-1:0] stage_count [0:PALETTE_DEPTH];

  logic advance;

  // The chain moves whenever the last stage is empty or being taken.
  assign advance     = ~stage_ctrl[PALETTE_DEPTH].valid | result_ready;
  assign pixel_ready = advance;

  // Entry to the chain: reduce each channel to its top three bits.
  always_comb begin
    stage_ctrl[0]          = '0;
    stage_ctrl[0].valid    = pixel_valid;
    stage_ctrl[0].clear    = first_of_image;
    stage_key[0]           = {red_in[7:5], green_in[7:5], blue_in[7:5]};
    stage_alpha[0]         = alpha_in;
    stage_index[0]         = '0;
    stage_count[0]         = '0;
  end

  // Row of search cells, one per palette entry.
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    rpb_cell #(
      .IW         (IW),
      .CW         (CW),
      .CELL_INDEX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_ctrl  (stage_ctrl[k]),
      .prev_key   (stage_key[k]),
      .prev_alpha (stage_alpha[k]),
      .prev_index (stage_index[k]),
      .prev_count (stage_count[k]),
      .ctrl       (stage_ctrl[k+1]),
      .key        (stage_key[k+1]),
      .alpha      (stage_alpha[k+1]),
      .index      (stage_index[k+1]),
      .count      (stage_count[k+1])
    );
  end

  // Result from the last stage; index and count are cut or padded to width.
  assign result_valid  = stage_ctrl[PALETTE_DEPTH].valid;
  assign mapped        = stage_ctrl[PALETTE_DEPTH].mapped;
  assign added_entry   = stage_ctrl[PALETTE_DEPTH].added;
  assign palette_index = 8'(stage_index[PALETTE_DEPTH]);
  assign entries_used  = 9'(stage_count[PALETTE_DEPTH]);

`ifndef SYNTHESIS
  logic [CW-1:0] last_index_plus_one;
  assign last_index_plus_one = CW'(stage_index[PALETTE_DEPTH]) + CW'(1);

  // A new entry is always a mapped one.
  a_added_is_mapped: assert property (@(posedge clk) disable iff (rst)
    result_valid && added_entry |-> mapped)
    else $error("added entry reported without a mapping");

  // A new entry is the last one, so the count is its index plus one.
  a_added_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && added_entry |-> stage_count[PALETTE_DEPTH] == last_index_plus_one)
    else $error("entry count does not follow the new entry index");

  // An unmapped item only arises on a full palette.
  a_unmapped_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && !mapped |-> stage_count[PALETTE_DEPTH] == CW'(PALETTE_DEPTH))
    else $error("unmapped item while the palette had room");

  // A held result keeps the whole chain still.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(stage_ctrl[1]))
    else $error("chain moved while the result was held");
`endif

endmodule : rgb_palette_builder_unit
`default_nettype wire

>>> rtl/rpb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette search cell
// Holds one palette entry, compares the passing item against it, claims the
// entry on a first miss and hands the item on through its output register.
// ----------------------------------------------------------------------------
module rpb_cell
  import rpb_pkg::*;
#(
  parameter int IW         = 8,
  parameter int CW         = 9,
  parameter int CELL_INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire ctrl_t         prev_ctrl,
  input  wire key_t          prev_key,
  input  wire alpha_t        prev_alpha,
  input  wire logic [IW-1:0] prev_index,
  input  wire logic [CW-1:0] prev_count,
  output ctrl_t              ctrl,
  output key_t               key,
  output alpha_t             alpha,
  output logic [IW-1:0]      index,
  output logic [CW-1:0]      count
);

  // Entry held by this cell.
  logic   occupied;
  key_t   entry_key;
  alpha_t entry_alpha;

  logic occ_eff;
  logic hit;
  logic claim;
  logic occ_next;

  ctrl_t         ctrl_next;
  logic [IW-1:0] index_next;
  logic [CW-1:0] count_next;

  // Compare against the entry as the item sees it, after any clear.
  always_comb begin
    occ_eff  = occupied & ~prev_ctrl.clear;
    hit      = prev_ctrl.valid & ~prev_ctrl.resolved & occ_eff & (entry_key == prev_key);
    claim    = prev_ctrl.valid & ~prev_ctrl.resolved & ~occ_eff;
    occ_next = occ_eff | claim;
  end

  // Result fields handed on to the next cell.
  always_comb begin
    ctrl_next          = prev_ctrl;
    ctrl_next.resolved = prev_ctrl.resolved | hit | claim;
    ctrl_next.mapped   = prev_ctrl.mapped | hit | claim;
    ctrl_next.added    = prev_ctrl.added | claim;
    index_next         = (hit | claim) ? IW'(CELL_INDEX) : prev_index;
    count_next         = prev_count + CW'(occ_next);
  end

  // Occupancy follows every item that passes; reset empties the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (advance && prev_ctrl.valid) begin
      occupied <= occ_next;
    end
  end

  // A claiming item writes its key and alpha into the entry.
  always_ff @(posedge clk) begin
    if (advance && claim) begin
      entry_key   <= prev_key;
      entry_alpha <= prev_alpha;
    end
  end

  // Stage register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (advance) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key   <= prev_key;
      alpha <= prev_alpha;
      index <= index_next;
      count <= count_next;
    end
  end

endmodule : rpb_cell
`default_nettype wire

>>> dv/rgb_palette_builder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB palette builder unit test
// Sends ARGB pixel items through the palette builder with bursty input and a
// stalling output, predicts each result from a software copy of the palette
// and compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module rgb_palette_builder_unit_test;
  import rpb_pkg::*;

  localparam int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH;
  localparam int KEY_COUNT     = 1 << KEY_W;
  localparam int PIXEL_TARGET  = 850;
  localparam int HOLD_TRIGGER  = 450;
  localparam int HOLD_CYCLES   = 700;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic       first;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic       mapped;
    logic       added;
    logic [8:0] used;
  } palette_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_THREE_OF_FOUR,
    READY_SPARSE
  } stall_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pixel_valid = 1'b0;
  logic       pixel_ready;
  logic       first_of_image = 1'b0;
  logic [7:0] alpha_in = 8'h00;
  logic [7:0] red_in = 8'h00;
  logic [7:0] green_in = 8'h00;
  logic [7:0] blue_in = 8'h00;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] palette_index;
  logic       mapped;
  logic       added_entry;
  logic [8:0] entries_used;

  pixel_item_t     pixels_to_send[$];
  palette_result_t expected_results[$];
  key_t            palette_keys[PALETTE_DEPTH];
  int              palette_fill = 0;
  int              mismatch_count = 0;
  int              pixels_accepted = 0;
  int              cycle_count = 0;

  // Sender burst state.
  pixel_item_t next_pixel;
  int          burst_left = 1;
  int          gap_left = 0;

  // Receiver stall state.
  stall_mode_e stall_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          stall_phase = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  rgb_palette_builder_unit #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .first_of_image(first_of_image),
    .alpha_in      (alpha_in),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .palette_index (palette_index),
    .mapped        (mapped),
    .added_entry   (added_entry),
    .entries_used  (entries_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Looks the reduced colour up in the palette copy, appends it on a miss
  // and queues the result that the block should give for this item.
  function automatic void predict_pixel(input logic first, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue);
    key_t            key;
    palette_result_t res;
    int              hit_at;
    key    = {red[7:5], green[7:5], blue[7:5]};
    hit_at = -1;
    res    = '0;
    if (first) begin
      palette_fill = 0;
    end
    for (int i = 0; i < palette_fill; i++) begin
      if (hit_at < 0 && palette_keys[i] == key) begin
        hit_at = i;
      end
    end
    if (hit_at >= 0) begin
      res.index  = 8'(hit_at);
      res.mapped = 1'b1;
    end else if (palette_fill < PALETTE_DEPTH) begin
      palette_keys[palette_fill] = key;
      res.index  = 8'(palette_fill);
      res.mapped = 1'b1;
      res.added  = 1'b1;
      palette_fill++;
    end
    res.used = 9'(palette_fill);
    expected_results.push_back(res);
  endfunction

  // Builds a pixel of the given reduced colour with random alpha and low bits.
  function automatic pixel_item_t make_pixel(input logic first, input key_t key);
    pixel_item_t p;
    p.first = first;
    p.alpha = 8'($urandom_range(0, 255));
    p.red   = {key[8:6], 5'($urandom_range(0, 31))};
    p.green = {key[5:3], 5'($urandom_range(0, 31))};
    p.blue  = {key[2:0], 5'($urandom_range(0, 31))};
    return p;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    key_t shuffled[KEY_COUNT];
    key_t pool[12];
    key_t swap_key;
    int   len;
    int   fresh;
    int   pick;
    int   j;
    int   pool_size;
    int   fill_images;

    // Directed items: channel extremes, low bits and alpha ignored in the
    // match, clearing in the middle of a stream and twice in a row.
    pixels_to_send.push_back('{1'b1, 8'h00, 8'h00, 8'h00, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'hff, 8'hff, 8'hff, 8'hff});
    pixels_to_send.push_back('{1'b0, 8'h7f, 8'h1f, 8'h1f, 8'h1f});
    pixels_to_send.push_back('{1'b0, 8'h00, 8'he0, 8'he0, 8'he0});
    pixels_to_send.push_back('{1'b0, 8'h80, 8'he0, 8'h00, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'h01, 8'h00, 8'he0, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'hfe, 8'h00, 8'h00, 8'he0});
    pixels_to_send.push_back('{1'b0, 8'h55, 8'h20, 8'h40, 8'h60});
    pixels_to_send.push_back('{1'b0, 8'haa, 8'h3f, 8'h5f, 8'h7f});
    pixels_to_send.push_back('{1'b0, 8'h33, 8'hff, 8'h00, 8'h1f});
    pixels_to_send.push_back('{1'b0, 8'hcc, 8'hea, 8'h15, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'h0f, 8'h80, 8'h80, 8'h80});
    pixels_to_send.push_back('{1'b1, 8'hf0, 8'hff, 8'hff, 8'hff});
    pixels_to_send.push_back('{1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'h12, 8'hff, 8'hff, 8'hff});
    pixels_to_send.push_back('{1'b1, 8'h00, 8'h00, 8'h00, 8'h00});
    pixels_to_send.push_back('{1'b1, 8'hff, 8'h00, 8'h00, 8'h00});
    pixels_to_send.push_back('{1'b0, 8'h5a, 8'h1f, 8'h1f, 8'h1f});
    pixels_to_send.push_back('{1'b0, 8'ha5, 8'ha0, 8'h55, 8'hc3});

    // Random images. Large images overfill the palette so that misses on a
    // full palette come up; small images reuse a few colours many times.
    // A second large image is only started while it still fits the target.
    fill_images = 0;
    while (pixels_to_send.size() < PIXEL_TARGET) begin
      if (fill_images == 0 ||
          (fill_images < 2 && pixels_to_send.size() + 340 <= PIXEL_TARGET &&
           $urandom_range(0, 5) == 0)) begin
        fill_images++;
        for (int i = 0; i < KEY_COUNT; i++) begin
          shuffled[i] = key_t'(i);
        end
        for (int i = KEY_COUNT - 1; i > 0; i--) begin
          j           = $urandom_range(0, i);
          swap_key    = shuffled[i];
          shuffled[i] = shuffled[j];
          shuffled[j] = swap_key;
        end
        len   = $urandom_range(300, 340);
        fresh = 0;
        for (int n = 0; n < len; n++) begin
          if (fresh >= PALETTE_DEPTH) begin
            pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, PALETTE_DEPTH - 1)
                                               : $urandom_range(PALETTE_DEPTH, KEY_COUNT - 1);
          end else if (fresh > 0 && $urandom_range(0, 9) == 0) begin
            pick = $urandom_range(0, fresh - 1);
          end else begin
            pick = fresh;
            fresh++;
          end
          pixels_to_send.push_back(make_pixel(n == 0, shuffled[pick]));
        end
      end else begin
        len       = $urandom_range(1, 40);
        pool_size = $urandom_range(1, 12);
        for (int i = 0; i < pool_size; i++) begin
          pool[i] = key_t'($urandom_range(0, KEY_COUNT - 1));
        end
        for (int n = 0; n < len; n++) begin
          if ($urandom_range(0, 4) == 0) begin
            pixels_to_send.push_back(make_pixel(n == 0,
                                                key_t'($urandom_range(0, KEY_COUNT - 1))));
          end else begin
            pixels_to_send.push_back(make_pixel(n == 0, pool[$urandom_range(0, pool_size - 1)]));
          end
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pixels_to_send.size() > 0 || pixel_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (PALETTE_DEPTH + 16) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Sender: predicts each accepted item and offers the next one in bursts
  // separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) begin
        predict_pixel(first_of_image, red_in, green_in, blue_in);
        pixels_accepted <= pixels_accepted + 1;
      end
      if (!pixel_valid || pixel_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (pixels_to_send.size() > 0) begin
          next_pixel = pixels_to_send.pop_front();
          first_of_image <= next_pixel.first;
          alpha_in       <= next_pixel.alpha;
          red_in         <= next_pixel.red;
          green_in       <= next_pixel.green;
          blue_in        <= next_pixel.blue;
          pixel_valid    <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: changes its stall pattern now and then, and once holds off long
  // enough for the search chain to fill and stall the input.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (!hold_done && pixels_accepted >= HOLD_TRIGGER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 300);
      end else begin
        mode_left--;
      end
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        case (stall_mode)
          READY_ALWAYS:        result_ready <= 1'b1;
          READY_COIN:          result_ready <= 1'($urandom_range(0, 1));
          READY_THREE_OF_FOUR: result_ready <= (stall_phase % 4) != 0;
          default:             result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    palette_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual index %0d mapped %0d",
                 $time, palette_index, mapped);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("palette_index", want.index, palette_index);
        check_field("mapped", want.mapped, mapped);
        check_field("added_entry", want.added, added_entry);
        check_field("entries_used", want.used, entries_used);
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/rpb_pkg.sv
rtl/rpb_cell.sv
rtl/rgb_palette_builder_unit.sv
dv/rgb_palette_builder_unit_test.sv
